FILE: rtl/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg
// Types and constants shared by the sorted priority queue modules.
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 32;
    localparam int PRIO_WIDTH = 16;
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int CFG_W      = 5;
    localparam int ADDR_W     = 3;
    localparam int PDATA_W    = 32;

    // operation codes
    localparam logic [1:0] OP_PEEK    = 2'd0;
    localparam logic [1:0] OP_ENQUEUE = 2'd1;
    localparam logic [1:0] OP_DEQUEUE = 2'd2;

    // register index (paddr / 4)
    localparam logic REG_MAX_ENTRIES = 1'b0;
    localparam logic [CFG_W-1:0] MAX_ENTRIES_RESET = CFG_W'(16);

    typedef struct packed {
        logic [1:0]                   operation;
        logic [DATA_WIDTH-1:0]        entry_data;
        logic signed [PRIO_WIDTH-1:0] entry_priority;
    } spq_in_t;

    typedef struct packed {
        logic                         ok;
        logic                         head_valid;
        logic [DATA_WIDTH-1:0]        head_data;
        logic signed [PRIO_WIDTH-1:0] head_priority;
        logic [4:0]                   entry_count;
    } spq_out_t;

    typedef struct packed {
        logic [DATA_WIDTH-1:0]        data;
        logic signed [PRIO_WIDTH-1:0] prio;
    } spq_entry_t;

    // per-cycle command broadcast to every cell
    typedef struct packed {
        logic enq;
        logic deq;
    } spq_ctrl_t;

endpackage

FILE: rtl/sorted_priority_queue.sv
// ----------------------------------------------------------------------------
// sorted_priority_queue
// Bounded priority queue kept sorted in a chain of shifting cells.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready/in_data) carries one operation per
// transfer: peek, enqueue or dequeue. Output channel (out_valid/out_ready/
// out_data) returns one result per operation: ok flag, head entry and count
// after the operation. Smallest priority is served first; equal priorities
// are served last-in first-out.
// The result is registered at the edge the operation is taken. One
// operation per cycle is sustained unless the receiver stalls, when the
// result register holds and in_ready drops until it is taken (in_ready =
// !out_valid || out_ready). Every cell compares the new priority against
// its own slot in parallel and shifts in one step. Reset empties the
// queue and sets the limit max_entries to 16. Write the limit through
// the APB port at address 0 only while the queue is idle; the block does
// not enforce it. Values above 16 act as 16, zero refuses every enqueue.
// ----------------------------------------------------------------------------
module sorted_priority_queue
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  spq_pkg::spq_in_t              in_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output spq_pkg::spq_out_t             out_data,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [spq_pkg::ADDR_W-1:0]    paddr,
    input  logic [spq_pkg::PDATA_W-1:0]   pwdata,
    output logic [spq_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready
);

    localparam int N = spq_pkg::DEPTH;

    logic [spq_pkg::CFG_W-1:0] max_entries;
    logic [spq_pkg::CNT_W-1:0] limit;
    logic [spq_pkg::CNT_W-1:0] count_reg;
    logic [spq_pkg::CNT_W-1:0] count_next;
    logic                      out_valid_reg;
    logic                      out_valid_next;
    spq_pkg::spq_out_t         out_reg;
    spq_pkg::spq_out_t         out_next;
    logic                      take;
    logic                      ok;
    spq_pkg::spq_ctrl_t        ctrl;
    spq_pkg::spq_entry_t       new_entry;

    spq_pkg::spq_entry_t       entry      [N];
    spq_pkg::spq_entry_t       entry_next [N];
    logic [N-1:0]              ins;
    logic [N-1:0]              occupied;

    spq_regs u_regs
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .max_entries (max_entries)
    );

    assign in_ready = !out_valid_reg || out_ready;
    assign take     = in_valid && in_ready;

    assign limit = (32'(max_entries) > N) ? spq_pkg::CNT_W'(N)
                                          : spq_pkg::CNT_W'(max_entries);

    assign new_entry.data = in_data.entry_data;
    assign new_entry.prio = in_data.entry_priority;

    always_comb
    begin
        ctrl.enq   = 1'b0;
        ctrl.deq   = 1'b0;
        ok         = 1'b0;
        count_next = count_reg;
        case (in_data.operation)
            spq_pkg::OP_ENQUEUE:
            begin
                ok = (count_reg < limit);
                ctrl.enq = take && ok;
                if (ctrl.enq)
                begin
                    count_next = count_reg + spq_pkg::CNT_W'(1);
                end
            end
            spq_pkg::OP_DEQUEUE:
            begin
                ok = (count_reg != '0);
                ctrl.deq = take && ok;
                if (ctrl.deq)
                begin
                    count_next = count_reg - spq_pkg::CNT_W'(1);
                end
            end
            default:
            begin
                ok = (count_reg != '0);
            end
        endcase
    end

    genvar g;
    generate
        for (g = 0; g < N; g++)
        begin : g_cell
            assign occupied[g] = (count_reg > spq_pkg::CNT_W'(g));

            if (g == 0)
            begin : g_first
                spq_cell u_cell
                (
                    .clk         (clk),
                    .ctrl        (ctrl),
                    .occupied    (occupied[g]),
                    .new_entry   (new_entry),
                    .left_entry  (new_entry),
                    .left_ins    (1'b0),
                    .right_entry (entry[g+1]),
                    .entry       (entry[g]),
                    .entry_next  (entry_next[g]),
                    .ins         (ins[g])
                );
            end
            else if (g == N - 1)
            begin : g_last
                spq_cell u_cell
                (
                    .clk         (clk),
                    .ctrl        (ctrl),
                    .occupied    (occupied[g]),
                    .new_entry   (new_entry),
                    .left_entry  (entry[g-1]),
                    .left_ins    (ins[g-1]),
                    .right_entry (entry[g]),
                    .entry       (entry[g]),
                    .entry_next  (entry_next[g]),
                    .ins         (ins[g])
                );
            end
            else
            begin : g_mid
                spq_cell u_cell
                (
                    .clk         (clk),
                    .ctrl        (ctrl),
                    .occupied    (occupied[g]),
                    .new_entry   (new_entry),
                    .left_entry  (entry[g-1]),
                    .left_ins    (ins[g-1]),
                    .right_entry (entry[g+1]),
                    .entry       (entry[g]),
                    .entry_next  (entry_next[g]),
                    .ins         (ins[g])
                );
            end
        end
    endgenerate

    // result reflects the head after this operation
    always_comb
    begin
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        if (take)
        begin
            out_valid_next         = 1'b1;
            out_next.ok            = ok;
            out_next.head_valid    = (count_next != '0);
            out_next.head_data     = (count_next != '0) ? entry_next[0].data : '0;
            out_next.head_priority = (count_next != '0) ? entry_next[0].prio : '0;
            out_next.entry_count   = 5'(count_next);
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

FILE: rtl/spq_cell.sv
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted chain: holds an entry, shifts right on insert
// and left on removal.
// ----------------------------------------------------------------------------
module spq_cell
(
    input  logic               clk,
    input  spq_pkg::spq_ctrl_t ctrl,
    input  logic               occupied,
    input  spq_pkg::spq_entry_t new_entry,
    input  spq_pkg::spq_entry_t left_entry,
    input  logic               left_ins,
    input  spq_pkg::spq_entry_t right_entry,
    output spq_pkg::spq_entry_t entry,
    output spq_pkg::spq_entry_t entry_next,
    output logic               ins
);

    spq_pkg::spq_entry_t entry_reg;

    // new entry belongs at or before this slot (ties go ahead)
    assign ins = !occupied || (new_entry.prio <= entry_reg.prio);

    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.enq && ins)
        begin
            entry_next = left_ins ? left_entry : new_entry;
        end
        else if (ctrl.deq)
        begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

FILE: rtl/spq_regs.sv
// ----------------------------------------------------------------------------
// spq_regs
// APB register file holding the entry limit.
// ----------------------------------------------------------------------------
module spq_regs
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [spq_pkg::ADDR_W-1:0]    paddr,
    input  logic [spq_pkg::PDATA_W-1:0]   pwdata,
    output logic [spq_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready,
    output logic [spq_pkg::CFG_W-1:0]     max_entries
);

    logic [spq_pkg::CFG_W-1:0] max_reg;
    logic [spq_pkg::CFG_W-1:0] max_next;
    logic                      sel_max;

    assign sel_max = (paddr[spq_pkg::ADDR_W-1] == spq_pkg::REG_MAX_ENTRIES);

    always_comb
    begin
        max_next = max_reg;
        if (psel && penable && pwrite && sel_max)
        begin
            max_next = pwdata[spq_pkg::CFG_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_reg <= spq_pkg::MAX_ENTRIES_RESET;
        end
        else
        begin
            max_reg <= max_next;
        end
    end

    assign prdata = sel_max ? spq_pkg::PDATA_W'(max_reg) : '0;
    assign pready = 1'b1;
    assign max_entries = max_reg;

endmodule

FILE: tb/sorted_priority_queue_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_priority_queue_test
// Drives peek/enqueue/dequeue operations into the sorted priority queue
// under several max_entries settings and random idling on both channels.
// Each transfer is predicted by a behavioral copy of the sorted list, and
// every result is checked field by field in transfer order.
// ----------------------------------------------------------------------------
module sorted_priority_queue_test;

    localparam logic [1:0] OP_UNUSED = 2'd3;   // decodes as a peek
    localparam int CLK_HALF   = 10;
    localparam int LONG_HOLD  = 120;
    localparam int STUCK_MAX  = 2000;

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         in_valid = 1'b0;
    logic                         in_ready;
    spq_pkg::spq_in_t             in_data = '0;
    logic                         out_valid;
    logic                         out_ready = 1'b0;
    spq_pkg::spq_out_t            out_data;
    logic                         psel = 1'b0;
    logic                         penable = 1'b0;
    logic                         pwrite = 1'b0;
    logic [spq_pkg::ADDR_W-1:0]   paddr = '0;
    logic [spq_pkg::PDATA_W-1:0]  pwdata = '0;
    logic [spq_pkg::PDATA_W-1:0]  prdata;
    logic                         pready;

    sorted_priority_queue u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always #CLK_HALF clk = ~clk;

    // shadow of the sorted list; slot 0 is the head
    logic [spq_pkg::DATA_WIDTH-1:0]        slot_payload [spq_pkg::DEPTH];
    logic signed [spq_pkg::PRIO_WIDTH-1:0] slot_rank [spq_pkg::DEPTH];
    int                                    stored = 0;
    logic [spq_pkg::CFG_W-1:0]             queue_limit = spq_pkg::MAX_ENTRIES_RESET;

    spq_pkg::spq_in_t  pending_ops [$];
    spq_pkg::spq_out_t expected_results [$];

    int  mismatches = 0;
    int  gap_left = 0;
    int  stall_left = 0;
    int  hold_left = 0;
    int  holds_requested = 0;
    int  holds_started = 0;
    int  stuck_cycles = 0;
    bit  src_gaps = 1'b0;
    bit  sink_gaps = 1'b0;

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    function automatic spq_pkg::spq_out_t apply_operation(spq_pkg::spq_in_t item);
        spq_pkg::spq_out_t res;
        int                cap;
        int                pos;
        res = '0;
        cap = (queue_limit > spq_pkg::DEPTH) ? spq_pkg::DEPTH : int'(queue_limit);
        case (item.operation)
            spq_pkg::OP_ENQUEUE:
            begin
                if (stored < cap)
                begin
                    pos = 0;
                    // new entry lands ahead of equal priorities
                    while (pos < stored && item.entry_priority > slot_rank[pos])
                        pos++;
                    for (int j = stored; j > pos; j--)
                    begin
                        slot_payload[j] = slot_payload[j-1];
                        slot_rank[j]    = slot_rank[j-1];
                    end
                    slot_payload[pos] = item.entry_data;
                    slot_rank[pos]    = item.entry_priority;
                    stored++;
                    res.ok = 1'b1;
                end
            end
            spq_pkg::OP_DEQUEUE:
            begin
                if (stored > 0)
                begin
                    for (int j = 0; j + 1 < stored; j++)
                    begin
                        slot_payload[j] = slot_payload[j+1];
                        slot_rank[j]    = slot_rank[j+1];
                    end
                    stored--;
                    res.ok = 1'b1;
                end
            end
            default:
                res.ok = (stored > 0);
        endcase
        if (stored > 0)
        begin
            res.head_valid    = 1'b1;
            res.head_data     = slot_payload[0];
            res.head_priority = slot_rank[0];
        end
        res.entry_count = 5'(stored);
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // driver
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
                expected_results.push_back(apply_operation(in_data));
            if (!in_valid || in_ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (pending_ops.size() > 0)
                begin
                    in_data  <= pending_ops.pop_front();
                    in_valid <= 1'b1;
                    gap_left = src_gaps ? pick_gap() : 0;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // monitor and receiver
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        spq_pkg::spq_out_t want;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result transfer: ok=%0d count=%0d",
                                 out_data.ok, out_data.entry_count);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (out_data.ok !== want.ok || out_data.head_valid !== want.head_valid ||
                        out_data.head_data !== want.head_data ||
                        out_data.head_priority !== want.head_priority ||
                        out_data.entry_count !== want.entry_count)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"mismatch: exp ok=%0d hv=%0d data=%h prio=%0d cnt=%0d",
                                      " | got ok=%0d hv=%0d data=%h prio=%0d cnt=%0d"},
                                     want.ok, want.head_valid, want.head_data,
                                     want.head_priority, want.entry_count,
                                     out_data.ok, out_data.head_valid, out_data.head_data,
                                     out_data.head_priority, out_data.entry_count);
                    end
                end
                stall_left = sink_gaps ? pick_gap() : 0;
            end
            if (holds_started < holds_requested)
            begin
                holds_started++;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // watchdog: cycles with no transfer on either channel
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            stuck_cycles = 0;
        else
            stuck_cycles++;
        if (stuck_cycles >= STUCK_MAX)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    task automatic push_op(logic [1:0] op, logic [spq_pkg::DATA_WIDTH-1:0] payload,
                           logic signed [spq_pkg::PRIO_WIDTH-1:0] rank);
        spq_pkg::spq_in_t item;
        item.operation      = op;
        item.entry_data     = payload;
        item.entry_priority = rank;
        pending_ops.push_back(item);
    endtask

    task automatic write_limit(logic [spq_pkg::CFG_W-1:0] value);
        logic [spq_pkg::PDATA_W-1:0] word;
        word = $urandom();
        word[spq_pkg::CFG_W-1:0] = value;   // upper bits are don't-care
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {spq_pkg::REG_MAX_ENTRIES, 2'b00};
        pwdata  <= word;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        queue_limit = value;
    endtask

    task automatic wait_idle();
        do
            @(negedge clk);
        while (pending_ops.size() != 0 || in_valid || expected_results.size() != 0);
        repeat (3) @(negedge clk);
    endtask

    function automatic logic signed [spq_pkg::PRIO_WIDTH-1:0] pick_rank();
        int r;
        r = $urandom_range(0, 9);
        if (r < 5)
            return spq_pkg::PRIO_WIDTH'($urandom());
        else if (r < 8)
            return spq_pkg::PRIO_WIDTH'(int'($urandom_range(0, 8)) - 4);   // ties likely
        case ($urandom_range(0, 5))
            0:       return 16'sh8000;
            1:       return -16'sd32767;
            2:       return -16'sd1;
            3:       return 16'sd0;
            4:       return 16'sd32766;
            default: return 16'sd32767;
        endcase
    endfunction

    // fill_only: enqueue-heavy throughout; otherwise fill then drain
    task automatic run_phase(int limit_value, int n_items, bit fill_only,
                             bit idle_src, bit idle_sink, bit long_hold);
        int         enq_pct;
        int         deq_pct;
        int         r;
        logic [1:0] op;
        write_limit(spq_pkg::CFG_W'(limit_value));
        src_gaps  = idle_src;
        sink_gaps = idle_sink;
        if (long_hold)
            holds_requested++;
        for (int i = 0; i < n_items; i++)
        begin
            if (fill_only || i < n_items / 2)
            begin
                enq_pct = fill_only ? 80 : 65;
                deq_pct = fill_only ? 10 : 25;
            end
            else
            begin
                enq_pct = 25;
                deq_pct = 65;
            end
            r = $urandom_range(0, 99);
            if (r < enq_pct)
                op = spq_pkg::OP_ENQUEUE;
            else if (r < enq_pct + deq_pct)
                op = spq_pkg::OP_DEQUEUE;
            else
                op = ($urandom_range(0, 3) == 0) ? OP_UNUSED : spq_pkg::OP_PEEK;
            push_op(op, $urandom(), pick_rank());
        end
        wait_idle();
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: empty queue, extremes, equal priorities, unused code
        src_gaps  = 1'b1;
        sink_gaps = 1'b1;
        push_op(spq_pkg::OP_PEEK,    32'h1234_5678, 16'sd77);
        push_op(spq_pkg::OP_DEQUEUE, 32'hFFFF_FFFF, -16'sd5);
        push_op(OP_UNUSED,           32'h0,         16'sd0);
        push_op(spq_pkg::OP_ENQUEUE, 32'h0000_0000, 16'sh8000);
        push_op(spq_pkg::OP_ENQUEUE, 32'hFFFF_FFFF, 16'sd32767);
        push_op(spq_pkg::OP_ENQUEUE, 32'hA5A5_A5A5, 16'sd0);
        push_op(spq_pkg::OP_ENQUEUE, 32'h0000_0001, 16'sd0);
        push_op(spq_pkg::OP_ENQUEUE, 32'h0000_0002, -16'sd1);
        push_op(spq_pkg::OP_PEEK,    32'hDEAD_BEEF, 16'sd1);
        push_op(OP_UNUSED,           32'hFFFF_FFFF, -16'sd1);
        for (int i = 0; i < 6; i++)
            push_op(spq_pkg::OP_DEQUEUE, $urandom(), spq_pkg::PRIO_WIDTH'($urandom()));
        wait_idle();

        // zero limit refuses every enqueue
        write_limit(spq_pkg::CFG_W'(0));
        push_op(spq_pkg::OP_ENQUEUE, 32'h5A5A_5A5A, 16'sd3);
        push_op(spq_pkg::OP_PEEK,    32'h0,         16'sd0);
        wait_idle();

        // back-to-back with a long receiver hold-off so the input stalls
        run_phase(31, 90, 1'b0, 1'b0, 1'b0, 1'b1);
        run_phase(16, 80, 1'b0, 1'b1, 1'b1, 1'b0);
        run_phase(1,  60, 1'b0, 1'b1, 1'b1, 1'b0);
        run_phase(2,  60, 1'b0, 1'b1, 1'b0, 1'b0);
        run_phase($urandom_range(3, 15), 80, 1'b0, 1'b0, 1'b1, 1'b0);
        run_phase(16, 90, 1'b1, 1'b1, 1'b1, 1'b0);
        // limit drops below the current fill level
        run_phase(3,  80, 1'b0, 1'b1, 1'b1, 1'b0);
        run_phase($urandom_range(17, 30), 60, 1'b0, 1'b1, 1'b1, 1'b0);

        repeat (5) @(negedge clk);
        if (expected_results.size() != 0)
            mismatches++;
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/spq_pkg.sv
rtl/spq_cell.sv
rtl/spq_regs.sv
rtl/sorted_priority_queue.sv
tb/sorted_priority_queue_test.sv
